/* design/hjd_pkg.sv */
package hjd_pkg;

  localparam int STABLE_SAMPLES = 5;
  localparam int WINDOW_W = STABLE_SAMPLES;
  localparam int COUNT_W = $clog2(STABLE_SAMPLES + 2);

  localparam int MV_W = 12;
  localparam int DELAY_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [MV_W-1:0] DEFAULT_SWITCH_LIMIT_MV = MV_W'(1100);
  localparam logic [WINDOW_W-1:0] ALL_LOW_WINDOW = '0;
  localparam logic [WINDOW_W-1:0] ALL_HIGH_WINDOW = '1;
  localparam logic [COUNT_W-1:0] SETTLE_COUNT = COUNT_W'(STABLE_SAMPLES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWITCH_LIMIT = 2'd0,
    CFG_DETECT_DELAY = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic headset_present;
    logic mic_switch_on;
    logic mic_ctrl_level;
    logic key_down;
    logic insert_event;
    logic remove_event;
    logic key_event;
  } result_t;

endpackage

/* design/hjd_in_if.sv */
interface hjd_in_if;
  logic                  valid;
  logic                  ready;
  logic                  detect_level;
  logic [hjd_pkg::MV_W-1:0] mic_voltage_mv;
  logic                  button_level;

  modport source (output valid, output detect_level, output mic_voltage_mv,
                  output button_level, input ready);
  modport sink (input valid, input detect_level, input mic_voltage_mv,
                input button_level, output ready);
endinterface

/* design/hjd_out_if.sv */
interface hjd_out_if;
  logic valid;
  logic ready;
  logic headset_present;
  logic mic_switch_on;
  logic mic_ctrl_level;
  logic key_down;
  logic insert_event;
  logic remove_event;
  logic key_event;

  modport source (output valid, output headset_present, output mic_switch_on,
                  output mic_ctrl_level, output key_down, output insert_event,
                  output remove_event, output key_event, input ready);
  modport sink (input valid, input headset_present, input mic_switch_on,
                input mic_ctrl_level, input key_down, input insert_event,
                input remove_event, input key_event, output ready);
endinterface

/* design/hjd_cfg_if.sv */
interface hjd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hjd_pkg::CFG_IDX_W-1:0]  index;
  logic [hjd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/headset_jack_detector_top.sv */
// Headset jack detector with debounce. Each input item is one sample tick
// (detect level, mic voltage, button level) and yields exactly one result
// item in the next cycle, holding the presence, mic switch, mic control
// pin and button state after that tick plus insert, remove and key pulses.
// The whole tick update passes once through the state registers, so an item
// is taken every clock as long as the result register is empty or being drained.
// After reset a jack check runs with no delay; configuration writes are
// always taken (ready held high), writes to unknown indexes are dropped.
module headset_jack_detector_top (
  input  logic clk,
  input  logic rst_n,
  hjd_in_if.sink    in_ch,
  hjd_out_if.source out_ch,
  hjd_cfg_if.sink   cfg_ch
);
  import hjd_pkg::*;

  logic [MV_W-1:0]    limit_r;
  logic [DELAY_W-1:0] delay_cfg_r;

  logic                check_pending_r, check_pending_nxt;
  logic [DELAY_W-1:0]  delay_count_r, delay_count_nxt;
  logic [COUNT_W-1:0]  sample_count_r, sample_count_nxt;
  logic [WINDOW_W-1:0] sample_window_r, sample_window_nxt;
  logic                prev_detect_r;
  logic                present_r, present_nxt;
  logic                switch_r, switch_nxt;
  logic                mic_pin_r, mic_pin_nxt;
  logic                button_r, button_nxt;

  logic    out_valid_r;
  result_t result_r, result_nxt;

  logic in_fire;
  logic below_limit;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign below_limit  = in_ch.mic_voltage_mv < limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= DEFAULT_SWITCH_LIMIT_MV;
      delay_cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SWITCH_LIMIT: limit_r     <= cfg_ch.data;
        CFG_DETECT_DELAY: delay_cfg_r <= cfg_ch.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    check_pending_nxt = check_pending_r;
    delay_count_nxt   = delay_count_r;
    sample_count_nxt  = sample_count_r;
    sample_window_nxt = sample_window_r;
    present_nxt       = present_r;
    switch_nxt        = switch_r;
    mic_pin_nxt       = mic_pin_r;
    button_nxt        = button_r;
    result_nxt        = '0;

    if (in_ch.detect_level != prev_detect_r && !check_pending_r) begin
      // edge tick: load the delay, restart the window
      check_pending_nxt = 1'b1;
      delay_count_nxt   = delay_cfg_r;
      sample_count_nxt  = '0;
      sample_window_nxt = '0;
    end else if (check_pending_r) begin
      if (delay_count_r != '0) begin
        delay_count_nxt = delay_count_r - DELAY_W'(1);
      end else begin
        sample_window_nxt = {sample_window_r[WINDOW_W-2:0], in_ch.detect_level};
        if (sample_count_r <= SETTLE_COUNT) begin
          sample_count_nxt = sample_count_r + COUNT_W'(1);
        end
        if (sample_count_nxt > SETTLE_COUNT &&
            (sample_window_nxt == ALL_LOW_WINDOW ||
             sample_window_nxt == ALL_HIGH_WINDOW)) begin
          check_pending_nxt = 1'b0;
          if (sample_window_nxt != ALL_LOW_WINDOW) begin
            if (!present_r) begin
              present_nxt             = 1'b1;
              result_nxt.insert_event = 1'b1;
              if (below_limit && !switch_r) begin
                mic_pin_nxt = 1'b0;
                switch_nxt  = 1'b1;
              end
            end else if (!below_limit && switch_r) begin
              switch_nxt  = 1'b0;
              mic_pin_nxt = 1'b0;
            end
          end else if (present_r) begin
            mic_pin_nxt             = 1'b1;
            present_nxt             = 1'b0;
            switch_nxt              = 1'b0;
            button_nxt              = 1'b0;
            result_nxt.key_event    = button_r;
            result_nxt.remove_event = 1'b1;
          end
        end
      end
    end

    // track the button only across ticks that keep the headset present
    if (present_r && present_nxt && in_ch.button_level != button_r) begin
      button_nxt           = in_ch.button_level;
      result_nxt.key_event = 1'b1;
    end

    result_nxt.headset_present = present_nxt;
    result_nxt.mic_switch_on   = switch_nxt;
    result_nxt.mic_ctrl_level  = mic_pin_nxt;
    result_nxt.key_down        = button_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_pending_r <= 1'b1;
      delay_count_r   <= '0;
      sample_count_r  <= '0;
      sample_window_r <= '0;
      prev_detect_r   <= 1'b0;
      present_r       <= 1'b0;
      switch_r        <= 1'b0;
      mic_pin_r       <= 1'b1;
      button_r        <= 1'b0;
    end else if (in_fire) begin
      check_pending_r <= check_pending_nxt;
      delay_count_r   <= delay_count_nxt;
      sample_count_r  <= sample_count_nxt;
      sample_window_r <= sample_window_nxt;
      prev_detect_r   <= in_ch.detect_level;
      present_r       <= present_nxt;
      switch_r        <= switch_nxt;
      mic_pin_r       <= mic_pin_nxt;
      button_r        <= button_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.headset_present = result_r.headset_present;
  assign out_ch.mic_switch_on   = result_r.mic_switch_on;
  assign out_ch.mic_ctrl_level  = result_r.mic_ctrl_level;
  assign out_ch.key_down        = result_r.key_down;
  assign out_ch.insert_event    = result_r.insert_event;
  assign out_ch.remove_event    = result_r.remove_event;
  assign out_ch.key_event       = result_r.key_event;

endmodule
